// ===== rtl/ttls_pkg.sv =====
// Shared constants, types and codes for the tiered token lottery scheduler.
package ttls_pkg;

   localparam int MAX_CORPUS_DEF  = 64;
   localparam int UPPER_SLOTS_DEF = 50;
   localparam int LOW_SLOTS_DEF   = 2;
   localparam int ID_BITS_DEF     = 16;

   localparam int RAND_W     = 31;
   localparam int OUT_ID_W   = 16;
   localparam int LIMIT_W    = 7;
   localparam int HTH_W      = 16;
   localparam int ETH_W      = 15;
   localparam int CSR_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int WEIGHT_W   = 16;
   localparam int TIER_W     = 2;

   localparam int HIGH_CAP   = 200;
   localparam int MID_CAP    = 50;
   localparam int TIER_MOD   = 100;
   localparam int HIGH_CUT   = 60;
   localparam int MID_CUT    = 30;
   localparam int HREM_W     = $clog2(HIGH_CAP + 1);
   localparam int MREM_W     = $clog2(MID_CAP + 1);
   localparam int MOD_W      = $clog2(TIER_MOD);

   localparam logic [RAND_W-1:0] TIER_RECIP = RAND_W'(1374389535);
   localparam int                TIER_SHIFT = 37;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CORPUS_LIMIT   = 2'd0,
      CSR_HIGH_THRESHOLD = 2'd1,
      CSR_EDGE_THRESHOLD = 2'd2
   } csr_index_type;

   typedef enum logic [TIER_W-1:0] {
      TIER_HIGH = 2'd0,
      TIER_MID  = 2'd1,
      TIER_LOW  = 2'd2
   } tier_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_MOD_A,
      ST_MOD_B,
      ST_READ,
      ST_RESP
   } state_type;

   localparam int OP_ADD  = 0;
   localparam int OP_PICK = 1;

endpackage

// ===== rtl/ttls_mod_unit.sv =====
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module ttls_mod_unit #(
   parameter int DIV_W = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ttls_pkg::RAND_W-1:0]   dividend,
   input  logic [DIV_W-1:0]              divisor,
   output logic                          done,
   output logic [DIV_W-1:0]              remainder
);
   localparam int CNT_W = $clog2(ttls_pkg::RAND_W + 1);

   logic [ttls_pkg::RAND_W-1:0] num_ff, num_in;
   logic [DIV_W-1:0]            den_ff, den_in;
   logic [DIV_W:0]              rem_ff, rem_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        run_ff, run_in;
   logic                        done_ff, done_in;
   logic [DIV_W:0]              trial;

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff[DIV_W-1:0], num_ff[ttls_pkg::RAND_W-1]};
      if (start) begin
         num_in = dividend;
         den_in = divisor;
         rem_in = '0;
         cnt_in = CNT_W'(ttls_pkg::RAND_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         num_in = {num_ff[ttls_pkg::RAND_W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
         end else begin
            rem_in = trial;
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[DIV_W-1:0];

endmodule

// ===== rtl/tiered_token_lottery_scheduler_core.sv =====
// Top level of the tiered token lottery scheduler: token rings, sequencer, config.
// Add: high, mid and low tokens are written in parallel until the high and mid tokens
// are all written (high tokens at most 200). Pick: tier remainder, entry remainder in
// the serial unit, a memory read, then the result; an empty ring skips to the result.
// One item at a time; busy is high from the cycle after acceptance back to idle.
// Sync reset clears positions, counts and thresholds, sets limit 64; rings stay unknown.
module tiered_token_lottery_scheduler_core #(
   parameter int MAX_CORPUS           = ttls_pkg::MAX_CORPUS_DEF,
   parameter int UPPER_SLOTS_PER_ITEM = ttls_pkg::UPPER_SLOTS_DEF,
   parameter int LOW_SLOTS_PER_ITEM   = ttls_pkg::LOW_SLOTS_DEF,
   parameter int ID_BITS              = ttls_pkg::ID_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_operation,
   input  logic [15:0]                       req_item_id,
   input  logic [ttls_pkg::WEIGHT_W-1:0]     req_item_weight,
   input  logic [ttls_pkg::RAND_W-1:0]       req_random_a,
   input  logic [ttls_pkg::RAND_W-1:0]       req_random_b,
   output logic                              rsp_valid,
   output logic [ttls_pkg::OUT_ID_W-1:0]     rsp_picked_id,
   output logic                              rsp_ring_empty,
   output logic [ttls_pkg::TIER_W-1:0]       rsp_tier_used,
   input  logic                              csr_write_enable,
   input  logic [ttls_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ttls_pkg::CSR_W-1:0]        csr_data
);
   localparam int UPPER_DEPTH = MAX_CORPUS * UPPER_SLOTS_PER_ITEM;
   localparam int LOW_DEPTH   = MAX_CORPUS * LOW_SLOTS_PER_ITEM;
   localparam int ULEN_W      = $clog2(UPPER_DEPTH + 1);
   localparam int LLEN_W      = $clog2(LOW_DEPTH + 1);
   localparam int HAW         = (UPPER_DEPTH > 1) ? $clog2(UPPER_DEPTH) : 1;
   localparam int LAW         = (LOW_DEPTH > 1) ? $clog2(LOW_DEPTH) : 1;
   localparam int DIV_W       = (ULEN_W > ttls_pkg::MOD_W) ? ULEN_W : ttls_pkg::MOD_W;
   localparam int LIM_W       = ttls_pkg::LIMIT_W;
   localparam int PROD_W      = 2 * ttls_pkg::RAND_W;

   ttls_pkg::state_type state_ff, state_in;

   logic [LIM_W-1:0]              limit_ff;
   logic [ttls_pkg::HTH_W-1:0]    hth_ff;
   logic [ttls_pkg::ETH_W-1:0]    eth_ff;

   logic [ID_BITS-1:0]     high_ring [UPPER_DEPTH];
   logic [ID_BITS-1:0]     mid_ring  [UPPER_DEPTH];
   logic [ID_BITS-1:0]     low_ring  [LOW_DEPTH];
   logic [ID_BITS-1:0]     hrd_ff, mrd_ff, lrd_ff;

   logic [ULEN_W-1:0] hpos_ff, hpos_in, mpos_ff, mpos_in, hcnt_ff, hcnt_in, mcnt_ff, mcnt_in;
   logic [LLEN_W-1:0] lpos_ff, lpos_in, lcnt_ff, lcnt_in;

   logic [ttls_pkg::HREM_W-1:0] hrem_ff, hrem_in;
   logic [ttls_pkg::MREM_W-1:0] mrem_ff, mrem_in;
   logic                        lpend_ff, lpend_in;
   logic [ID_BITS-1:0]          id_ff, id_in;
   logic [ttls_pkg::RAND_W-1:0] b_ff, b_in;
   logic [ttls_pkg::MOD_W-1:0]  alo_ff, alo_in, qlo_ff, qlo_in;
   ttls_pkg::tier_type          tier_ff, tier_in;
   logic                        empty_ff, empty_in;
   logic [DIV_W-1:0]            idx_ff, idx_in;

   logic [LIM_W-1:0]   lim;
   logic [ULEN_W-1:0]  ulen, hp, mp, hp1, mp1;
   logic [LLEN_W-1:0]  llen, lp, lp1;
   logic               hwe, mwe, lwe;
   logic [ttls_pkg::WEIGHT_W-1:0] wclamp;
   logic               high_ok, mid_ok;
   logic [ttls_pkg::HREM_W-1:0] hcount_new;
   logic [ttls_pkg::MREM_W-1:0] mcount_new;
   logic [DIV_W-1:0]   filled;

   logic                        div_start, div_done;
   logic [ttls_pkg::RAND_W-1:0] div_num;
   logic [DIV_W-1:0]            div_den, div_rem;
   logic [PROD_W-1:0]           a_prod;
   logic [ttls_pkg::MOD_W-1:0]  a_mod;

   ttls_mod_unit #(.DIV_W(DIV_W)) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_num),
      .divisor   (div_den),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_comb begin
      lim = limit_ff;
      if (limit_ff == '0) begin
         lim = LIM_W'(1);
      end else if (32'(limit_ff) > 32'(MAX_CORPUS)) begin
         lim = LIM_W'(MAX_CORPUS);
      end
      ulen = ULEN_W'(lim) * ULEN_W'(UPPER_SLOTS_PER_ITEM);
      llen = LLEN_W'(lim) * LLEN_W'(LOW_SLOTS_PER_ITEM);

      hp  = (hpos_ff >= ulen) ? '0 : hpos_ff;
      mp  = (mpos_ff >= ulen) ? '0 : mpos_ff;
      lp  = (lpos_ff >= llen) ? '0 : lpos_ff;
      hp1 = hp + 1'b1;
      mp1 = mp + 1'b1;
      lp1 = lp + 1'b1;

      high_ok = (req_item_weight >= hth_ff);
      wclamp  = req_item_weight;
      if (high_ok && (req_item_weight > ttls_pkg::WEIGHT_W'(ttls_pkg::HIGH_CAP))) begin
         wclamp = ttls_pkg::WEIGHT_W'(ttls_pkg::HIGH_CAP);
      end
      hcount_new = high_ok ? ttls_pkg::HREM_W'(wclamp) : '0;
      mid_ok     = (wclamp >= {eth_ff, 1'b0});
      mcount_new = '0;
      if (mid_ok) begin
         mcount_new = (wclamp > ttls_pkg::WEIGHT_W'(ttls_pkg::MID_CAP))
                      ? ttls_pkg::MREM_W'(ttls_pkg::MID_CAP) : ttls_pkg::MREM_W'(wclamp);
      end

      a_prod = PROD_W'(req_random_a) * PROD_W'(ttls_pkg::TIER_RECIP);
      a_mod  = alo_ff - ttls_pkg::MOD_W'(qlo_ff * ttls_pkg::MOD_W'(ttls_pkg::TIER_MOD));
      tier_in = tier_ff;
      if (state_ff == ttls_pkg::ST_MOD_A) begin
         if (a_mod > ttls_pkg::MOD_W'(ttls_pkg::HIGH_CUT)) begin
            tier_in = ttls_pkg::TIER_HIGH;
         end else if (a_mod > ttls_pkg::MOD_W'(ttls_pkg::MID_CUT)) begin
            tier_in = ttls_pkg::TIER_MID;
         end else begin
            tier_in = ttls_pkg::TIER_LOW;
         end
      end
      unique case (tier_in)
         ttls_pkg::TIER_HIGH: filled = DIV_W'((hcnt_ff < ulen) ? hcnt_ff : ulen);
         ttls_pkg::TIER_MID:  filled = DIV_W'((mcnt_ff < ulen) ? mcnt_ff : ulen);
         default:             filled = DIV_W'((lcnt_ff < llen) ? lcnt_ff : llen);
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      hpos_in   = hpos_ff;
      mpos_in   = mpos_ff;
      lpos_in   = lpos_ff;
      hcnt_in   = hcnt_ff;
      mcnt_in   = mcnt_ff;
      lcnt_in   = lcnt_ff;
      hrem_in   = hrem_ff;
      mrem_in   = mrem_ff;
      lpend_in  = lpend_ff;
      id_in     = id_ff;
      b_in      = b_ff;
      alo_in    = alo_ff;
      qlo_in    = qlo_ff;
      empty_in  = empty_ff;
      idx_in    = idx_ff;
      hwe       = 1'b0;
      mwe       = 1'b0;
      lwe       = 1'b0;
      div_start = 1'b0;
      div_num   = b_ff;
      div_den   = filled;
      busy      = (state_ff != ttls_pkg::ST_IDLE);
      rsp_valid = 1'b0;
      unique case (state_ff)
         ttls_pkg::ST_IDLE: begin
            if (start) begin
               if (req_operation == 1'(ttls_pkg::OP_ADD)) begin
                  id_in    = ID_BITS'(req_item_id);
                  hrem_in  = hcount_new;
                  mrem_in  = mcount_new;
                  lpend_in = 1'b1;
                  state_in = ttls_pkg::ST_ADD;
               end else begin
                  b_in     = req_random_b;
                  alo_in   = req_random_a[ttls_pkg::MOD_W-1:0];
                  qlo_in   = a_prod[ttls_pkg::TIER_SHIFT +: ttls_pkg::MOD_W];
                  state_in = ttls_pkg::ST_MOD_A;
               end
            end
         end
         ttls_pkg::ST_ADD: begin
            if (hrem_ff != '0) begin
               hwe     = 1'b1;
               hpos_in = (hp1 == ulen) ? '0 : hp1;
               if (hcnt_ff < ulen) hcnt_in = hcnt_ff + 1'b1;
               hrem_in = hrem_ff - 1'b1;
            end
            if (mrem_ff != '0) begin
               mwe     = 1'b1;
               mpos_in = (mp1 == ulen) ? '0 : mp1;
               if (mcnt_ff < ulen) mcnt_in = mcnt_ff + 1'b1;
               mrem_in = mrem_ff - 1'b1;
            end
            if (lpend_ff) begin
               lwe      = 1'b1;
               lpos_in  = (lp1 == llen) ? '0 : lp1;
               if (lcnt_ff < llen) lcnt_in = lcnt_ff + 1'b1;
               lpend_in = 1'b0;
            end
            if ((hrem_ff <= ttls_pkg::HREM_W'(1)) && (mrem_ff <= ttls_pkg::MREM_W'(1))) begin
               state_in = ttls_pkg::ST_IDLE;
            end
         end
         ttls_pkg::ST_MOD_A: begin
            if (filled == '0) begin
               empty_in = 1'b1;
               state_in = ttls_pkg::ST_RESP;
            end else begin
               empty_in  = 1'b0;
               div_start = 1'b1;
               state_in  = ttls_pkg::ST_MOD_B;
            end
         end
         ttls_pkg::ST_MOD_B: begin
            if (div_done) begin
               idx_in   = div_rem;
               state_in = ttls_pkg::ST_READ;
            end
         end
         ttls_pkg::ST_READ: begin
            state_in = ttls_pkg::ST_RESP;
         end
         ttls_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
            state_in  = ttls_pkg::ST_IDLE;
         end
         default: begin
            state_in = ttls_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ttls_pkg::ST_IDLE;
         limit_ff <= ttls_pkg::LIMIT_RESET;
         hth_ff   <= '0;
         eth_ff   <= '0;
         hpos_ff  <= '0;
         mpos_ff  <= '0;
         lpos_ff  <= '0;
         hcnt_ff  <= '0;
         mcnt_ff  <= '0;
         lcnt_ff  <= '0;
         hrem_ff  <= '0;
         mrem_ff  <= '0;
         lpend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         hpos_ff  <= hpos_in;
         mpos_ff  <= mpos_in;
         lpos_ff  <= lpos_in;
         hcnt_ff  <= hcnt_in;
         mcnt_ff  <= mcnt_in;
         lcnt_ff  <= lcnt_in;
         hrem_ff  <= hrem_in;
         mrem_ff  <= mrem_in;
         lpend_ff <= lpend_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               ttls_pkg::CSR_CORPUS_LIMIT:   limit_ff <= csr_data[LIM_W-1:0];
               ttls_pkg::CSR_HIGH_THRESHOLD: hth_ff   <= csr_data[ttls_pkg::HTH_W-1:0];
               ttls_pkg::CSR_EDGE_THRESHOLD: eth_ff   <= csr_data[ttls_pkg::ETH_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      id_ff    <= id_in;
      b_ff     <= b_in;
      alo_ff   <= alo_in;
      qlo_ff   <= qlo_in;
      tier_ff  <= tier_in;
      empty_ff <= empty_in;
      idx_ff   <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (hwe) high_ring[hp[HAW-1:0]] <= id_ff;
      if (mwe) mid_ring[mp[HAW-1:0]]  <= id_ff;
      if (lwe) low_ring[lp[LAW-1:0]]  <= id_ff;
      hrd_ff <= high_ring[idx_ff[HAW-1:0]];
      mrd_ff <= mid_ring[idx_ff[HAW-1:0]];
      lrd_ff <= low_ring[idx_ff[LAW-1:0]];
   end

   always_comb begin
      rsp_ring_empty = empty_ff;
      rsp_tier_used  = tier_ff;
      unique case (tier_ff)
         ttls_pkg::TIER_HIGH: rsp_picked_id = ttls_pkg::OUT_ID_W'(hrd_ff);
         ttls_pkg::TIER_MID:  rsp_picked_id = ttls_pkg::OUT_ID_W'(mrd_ff);
         default:             rsp_picked_id = ttls_pkg::OUT_ID_W'(lrd_ff);
      endcase
      if (empty_ff) rsp_picked_id = '0;
   end

`ifndef ASSERT_OFF
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result beat longer than one cycle");
   a_idle_after_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("block not idle after result beat");
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ring_empty) |-> (rsp_picked_id == '0))
      else $error("empty ring result carries an id");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted item left block idle");
`endif

endmodule
